// ----- design/cpc_pkg.sv -----
// Shared types, widths and helpers for the circle pair collision pipeline.
// No dependencies; every design file imports this package.
package cpc_pkg;

  localparam int unsigned VAL_W     = 24;
  localparam int unsigned RAD_W     = 16;
  localparam int unsigned REST_W    = 9;
  localparam logic [REST_W-1:0] REST_RST = 9'd205;

  // Root unit: the contact test bounds the radicand below the squared radius sum.
  localparam int unsigned SQ_IN_W   = 2 * (RAD_W + 1);
  localparam int unsigned SQ_OUT_W  = RAD_W + 1;
  localparam int unsigned SQRT_LAT  = SQ_OUT_W;

  // Rounding divider: one quotient bit per stage plus a setup stage.
  localparam int unsigned DIV_NUM_W = 54;
  localparam int unsigned DIV_DEN_W = 25;
  localparam int unsigned DIV_Q_W   = 30;
  localparam int unsigned DIV_REM_W = DIV_NUM_W + 1;
  localparam int unsigned DIV_LAT   = DIV_Q_W + 1;

  localparam int unsigned SEP_W     = RAD_W + 2;
  localparam int unsigned VN_W      = 26;
  localparam int unsigned NV_W      = 30;
  localparam int unsigned SAT_IN_W  = DIV_Q_W + 1;

  typedef enum logic [1:0] {
    STAT_NONE  = 2'd0,
    STAT_HIT   = 2'd1,
    STAT_DEGEN = 2'd2
  } cpc_status_e;

  typedef struct packed {
    logic signed [VAL_W-1:0] a_pos_x;
    logic signed [VAL_W-1:0] a_pos_y;
    logic signed [VAL_W-1:0] a_vel_x;
    logic signed [VAL_W-1:0] a_vel_y;
    logic        [RAD_W-1:0] a_radius;
    logic        [RAD_W-1:0] a_mass;
    logic signed [VAL_W-1:0] b_pos_x;
    logic signed [VAL_W-1:0] b_pos_y;
    logic signed [VAL_W-1:0] b_vel_x;
    logic signed [VAL_W-1:0] b_vel_y;
    logic        [RAD_W-1:0] b_radius;
    logic        [RAD_W-1:0] b_mass;
  } cpc_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] new_a_pos_x;
    logic signed [VAL_W-1:0] new_a_pos_y;
    logic signed [VAL_W-1:0] new_a_vel_x;
    logic signed [VAL_W-1:0] new_a_vel_y;
    logic signed [VAL_W-1:0] new_b_pos_x;
    logic signed [VAL_W-1:0] new_b_pos_y;
    logic signed [VAL_W-1:0] new_b_vel_x;
    logic signed [VAL_W-1:0] new_b_vel_y;
    cpc_status_e             status;
  } cpc_out_t;

  // Per-item context carried down the pipeline; fields fill in as they appear.
  typedef struct packed {
    cpc_in_t                 item;
    logic                    hit;
    logic                    degen;
    logic signed [SEP_W-1:0] dx;
    logic signed [SEP_W-1:0] dy;
    logic [SQ_OUT_W-1:0]     rsum;
    logic [SQ_OUT_W-1:0]     ctr_dist;
    logic signed [SEP_W-1:0] sx;
    logic signed [SEP_W-1:0] sy;
    logic signed [VN_W-1:0]  vta;
    logic signed [VN_W-1:0]  vtb;
    logic signed [NV_W-1:0]  na;
    logic signed [NV_W-1:0]  nb;
  } cpc_ctx_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-VAL_W:0] top;
    top = v[SAT_IN_W-1:VAL_W-1];
    if (&top || ~|top) begin
      sat_val = v[VAL_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  endfunction

endpackage

// ----- design/circle_pair_collision.sv -----
// Two-disc collision response pipeline: separation and restitution impulse.
// Depends on cpc_pkg, cpc_isqrt and cpc_div.
//
// One disc pair enters per cycle while no held output stalls it, and passes three
// setup stages, a 17-stage square root, two multiply stages and a 31-stage
// divider for the normal and tangential projections, three stages for the
// impulse, a 31-stage divider by the mass sum, two stages to rotate back, a
// 31-stage divider by the distance, and the output register. A held output beat
// freezes the whole pipeline, so input ready follows output ready while a result
// is waiting. Restitution is read live and must only change while the pipeline
// is empty.
module circle_pair_collision
  import cpc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cpc_in_t           in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cpc_out_t          out_data_o,
  input  logic              cfg_we_i,
  input  logic [REST_W-1:0] cfg_wdata_i
);

  localparam int unsigned NDA = 6;
  localparam int unsigned NDB = 2;
  localparam int unsigned NDC = 4;

  logic adv;
  logic [REST_W-1:0] rest_q;

  // valid bits
  logic t1_vld_q, t2_vld_q, t3_vld_q, u1_vld_q, u2_vld_q;
  logic w1_vld_q, w2_vld_q, w3_vld_q, x1_vld_q, x2_vld_q, out_vld_q;
  logic [SQRT_LAT-1:0] sq_vld_q;
  logic [DIV_LAT-1:0]  da_vld_q, db_vld_q, dc_vld_q;

  // setup stages
  cpc_in_t            t1_item_q, t2_item_q;
  logic signed [24:0] t1_dx_q, t1_dy_q, t2_dx_q, t2_dy_q;
  logic [SQ_OUT_W-1:0] t1_rsum_q, t2_rsum_q;
  logic               t1_degen_q, t2_degen_q;
  logic [47:0]        t2_dxx_q, t2_dyy_q;
  logic [SQ_IN_W-1:0] t2_rsq_q;
  logic [SQ_IN_W-1:0] t3_rad_q;
  cpc_ctx_t           t3_ctx_d, t3_ctx_q;

  logic signed [24:0] t1_dx_d, t1_dy_d;
  logic [SQ_OUT_W-1:0] t1_msum;
  logic signed [49:0] t2_dxx_full, t2_dyy_full;
  logic [48:0]        t3_ssum;

  // delay lines
  cpc_ctx_t sq_ctx_q [SQRT_LAT];
  cpc_ctx_t da_ctx_q [DIV_LAT];
  cpc_ctx_t db_ctx_q [DIV_LAT];
  cpc_ctx_t dc_ctx_q [DIV_LAT];

  // projection stages
  logic [SQ_OUT_W-1:0] sq_root;
  cpc_ctx_t            u1_ctx_d, u1_ctx_q, u2_ctx_q;
  logic signed [SEP_W-1:0] u1_ov;
  logic signed [35:0]  u1_ovx_q, u1_ovy_q;
  logic signed [41:0]  u1_vp_q [8];
  logic signed [42:0]  u2_num_q [NDA];
  logic signed [DIV_Q_W:0] qa [NDA];

  // impulse stages
  cpc_ctx_t            w1_ctx_d, w1_ctx_q, w2_ctx_q, w3_ctx_q;
  logic signed [VN_W-1:0] w_vna, w_vnb;
  logic signed [16:0]  w_mdiff, w_am, w_bm;
  logic signed [42:0]  w1_p_q [4];
  logic signed [43:0]  w2_pre_q [NDB];
  logic signed [DIV_NUM_W-1:0] w3_num_q [NDB];
  logic signed [REST_W:0] rest_s;
  logic [SQ_OUT_W-1:0] w3_msum;
  logic [DIV_DEN_W-1:0] den_b;
  logic signed [DIV_Q_W:0] qb [NDB];

  // rotate-back stages
  cpc_ctx_t            x1_ctx_d, x1_ctx_q, x2_ctx_q;
  logic signed [47:0]  x1_p_q [8];
  logic signed [48:0]  x2_num_q [NDC];
  logic signed [DIV_Q_W:0] qc [NDC];

  // output
  cpc_ctx_t            dc_ctx;
  cpc_out_t            out_d, out_q;
  logic signed [24:0]  npax, npay, npbx, npby;

  assign adv         = !out_vld_q || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rest_q <= REST_RST;
    end else if (cfg_we_i) begin
      rest_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_vld_q  <= 1'b0;
      t2_vld_q  <= 1'b0;
      t3_vld_q  <= 1'b0;
      sq_vld_q  <= '0;
      u1_vld_q  <= 1'b0;
      u2_vld_q  <= 1'b0;
      da_vld_q  <= '0;
      w1_vld_q  <= 1'b0;
      w2_vld_q  <= 1'b0;
      w3_vld_q  <= 1'b0;
      db_vld_q  <= '0;
      x1_vld_q  <= 1'b0;
      x2_vld_q  <= 1'b0;
      dc_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      t1_vld_q  <= in_valid_i;
      t2_vld_q  <= t1_vld_q;
      t3_vld_q  <= t2_vld_q;
      sq_vld_q  <= {sq_vld_q[SQRT_LAT-2:0], t3_vld_q};
      u1_vld_q  <= sq_vld_q[SQRT_LAT-1];
      u2_vld_q  <= u1_vld_q;
      da_vld_q  <= {da_vld_q[DIV_LAT-2:0], u2_vld_q};
      w1_vld_q  <= da_vld_q[DIV_LAT-1];
      w2_vld_q  <= w1_vld_q;
      w3_vld_q  <= w2_vld_q;
      db_vld_q  <= {db_vld_q[DIV_LAT-2:0], w3_vld_q};
      x1_vld_q  <= db_vld_q[DIV_LAT-1];
      x2_vld_q  <= x1_vld_q;
      dc_vld_q  <= {dc_vld_q[DIV_LAT-2:0], x2_vld_q};
      out_vld_q <= dc_vld_q[DIV_LAT-1];
    end
  end

  // ---------------------------------------------------------------- setup
  assign t1_dx_d = {in_data_i.b_pos_x[VAL_W-1], in_data_i.b_pos_x}
                 - {in_data_i.a_pos_x[VAL_W-1], in_data_i.a_pos_x};
  assign t1_dy_d = {in_data_i.b_pos_y[VAL_W-1], in_data_i.b_pos_y}
                 - {in_data_i.a_pos_y[VAL_W-1], in_data_i.a_pos_y};
  assign t1_msum = {1'b0, in_data_i.a_mass} + {1'b0, in_data_i.b_mass};

  assign t2_dxx_full = t1_dx_q * t1_dx_q;
  assign t2_dyy_full = t1_dy_q * t1_dy_q;
  assign t3_ssum     = {1'b0, t2_dxx_q} + {1'b0, t2_dyy_q};

  // floor(sqrt(s)) < rsum exactly when s < rsum^2
  always_comb begin
    t3_ctx_d       = '0;
    t3_ctx_d.item  = t2_item_q;
    t3_ctx_d.degen = t2_degen_q;
    t3_ctx_d.hit   = !t2_degen_q && (t3_ssum < 49'(t2_rsq_q));
    t3_ctx_d.dx    = t2_dx_q[SEP_W-1:0];
    t3_ctx_d.dy    = t2_dy_q[SEP_W-1:0];
    t3_ctx_d.rsum  = t2_rsum_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_item_q  <= in_data_i;
      t1_dx_q    <= t1_dx_d;
      t1_dy_q    <= t1_dy_d;
      t1_rsum_q  <= {1'b0, in_data_i.a_radius} + {1'b0, in_data_i.b_radius};
      t1_degen_q <= (t1_dx_d == '0 && t1_dy_d == '0) || t1_msum == '0;

      t2_item_q  <= t1_item_q;
      t2_dx_q    <= t1_dx_q;
      t2_dy_q    <= t1_dy_q;
      t2_rsum_q  <= t1_rsum_q;
      t2_degen_q <= t1_degen_q;
      t2_dxx_q   <= t2_dxx_full[47:0];
      t2_dyy_q   <= t2_dyy_full[47:0];
      t2_rsq_q   <= t1_rsum_q * t1_rsum_q;

      t3_rad_q   <= t3_ssum[SQ_IN_W-1:0];
      t3_ctx_q   <= t3_ctx_d;
    end
  end

  cpc_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (t3_rad_q),
    .root_o (sq_root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_ctx_q[0] <= t3_ctx_q;
      for (int k = 1; k < SQRT_LAT; k++) sq_ctx_q[k] <= sq_ctx_q[k-1];
      da_ctx_q[0] <= u2_ctx_q;
      for (int k = 1; k < DIV_LAT; k++) da_ctx_q[k] <= da_ctx_q[k-1];
      db_ctx_q[0] <= w3_ctx_q;
      for (int k = 1; k < DIV_LAT; k++) db_ctx_q[k] <= db_ctx_q[k-1];
      dc_ctx_q[0] <= x2_ctx_q;
      for (int k = 1; k < DIV_LAT; k++) dc_ctx_q[k] <= dc_ctx_q[k-1];
    end
  end

  // ----------------------------------------------------------- projection
  always_comb begin
    u1_ctx_d          = sq_ctx_q[SQRT_LAT-1];
    u1_ctx_d.ctr_dist = sq_root;
  end

  assign u1_ov = {1'b0, u1_ctx_d.rsum} - {1'b0, sq_root};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      u1_ctx_q    <= u1_ctx_d;
      u1_ovx_q    <= u1_ov * u1_ctx_d.dx;
      u1_ovy_q    <= u1_ov * u1_ctx_d.dy;
      u1_vp_q[0]  <= u1_ctx_d.item.a_vel_x * u1_ctx_d.dx;
      u1_vp_q[1]  <= u1_ctx_d.item.a_vel_y * u1_ctx_d.dy;
      u1_vp_q[2]  <= u1_ctx_d.item.a_vel_y * u1_ctx_d.dx;
      u1_vp_q[3]  <= u1_ctx_d.item.a_vel_x * u1_ctx_d.dy;
      u1_vp_q[4]  <= u1_ctx_d.item.b_vel_x * u1_ctx_d.dx;
      u1_vp_q[5]  <= u1_ctx_d.item.b_vel_y * u1_ctx_d.dy;
      u1_vp_q[6]  <= u1_ctx_d.item.b_vel_y * u1_ctx_d.dx;
      u1_vp_q[7]  <= u1_ctx_d.item.b_vel_x * u1_ctx_d.dy;

      u2_ctx_q    <= u1_ctx_q;
      u2_num_q[0] <= 43'(u1_ovx_q);
      u2_num_q[1] <= 43'(u1_ovy_q);
      u2_num_q[2] <= 43'(u1_vp_q[0]) + 43'(u1_vp_q[1]);
      u2_num_q[3] <= 43'(u1_vp_q[2]) - 43'(u1_vp_q[3]);
      u2_num_q[4] <= 43'(u1_vp_q[4]) + 43'(u1_vp_q[5]);
      u2_num_q[5] <= 43'(u1_vp_q[6]) - 43'(u1_vp_q[7]);
    end
  end

  for (genvar g = 0; g < NDA; g++) begin : g_div_a
    cpc_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (DIV_NUM_W'(u2_num_q[g])),
      .den_i (DIV_DEN_W'(u2_ctx_q.ctr_dist)),
      .quo_o (qa[g])
    );
  end

  // -------------------------------------------------------------- impulse
  always_comb begin
    w1_ctx_d     = da_ctx_q[DIV_LAT-1];
    w1_ctx_d.sx  = $signed(qa[0][SEP_W-1:0]);
    w1_ctx_d.sy  = $signed(qa[1][SEP_W-1:0]);
    w1_ctx_d.vta = $signed(qa[3][VN_W-1:0]);
    w1_ctx_d.vtb = $signed(qa[5][VN_W-1:0]);
  end

  assign w_vna   = $signed(qa[2][VN_W-1:0]);
  assign w_vnb   = $signed(qa[4][VN_W-1:0]);
  assign w_am    = {1'b0, w1_ctx_d.item.a_mass};
  assign w_bm    = {1'b0, w1_ctx_d.item.b_mass};
  assign w_mdiff = w_am - w_bm;
  assign rest_s  = {1'b0, rest_q};
  assign w3_msum = {1'b0, w3_ctx_q.item.a_mass} + {1'b0, w3_ctx_q.item.b_mass};
  assign den_b   = {w3_msum, 8'd0};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w1_ctx_q    <= w1_ctx_d;
      w1_p_q[0]   <= w_vna * w_mdiff;
      w1_p_q[1]   <= w_vnb * w_bm;
      w1_p_q[2]   <= w_vnb * (-w_mdiff);
      w1_p_q[3]   <= w_vna * w_am;

      w2_ctx_q    <= w1_ctx_q;
      w2_pre_q[0] <= 44'(w1_p_q[0]) + (44'(w1_p_q[1]) <<< 1);
      w2_pre_q[1] <= 44'(w1_p_q[2]) + (44'(w1_p_q[3]) <<< 1);

      w3_ctx_q    <= w2_ctx_q;
      w3_num_q[0] <= rest_s * w2_pre_q[0];
      w3_num_q[1] <= rest_s * w2_pre_q[1];
    end
  end

  for (genvar g = 0; g < NDB; g++) begin : g_div_b
    cpc_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (w3_num_q[g]),
      .den_i (den_b),
      .quo_o (qb[g])
    );
  end

  // ---------------------------------------------------------- rotate back
  always_comb begin
    x1_ctx_d    = db_ctx_q[DIV_LAT-1];
    x1_ctx_d.na = $signed(qb[0][NV_W-1:0]);
    x1_ctx_d.nb = $signed(qb[1][NV_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x1_ctx_q    <= x1_ctx_d;
      x1_p_q[0]   <= x1_ctx_d.na * x1_ctx_d.dx;
      x1_p_q[1]   <= 48'(x1_ctx_d.vta * x1_ctx_d.dy);
      x1_p_q[2]   <= x1_ctx_d.na * x1_ctx_d.dy;
      x1_p_q[3]   <= 48'(x1_ctx_d.vta * x1_ctx_d.dx);
      x1_p_q[4]   <= x1_ctx_d.nb * x1_ctx_d.dx;
      x1_p_q[5]   <= 48'(x1_ctx_d.vtb * x1_ctx_d.dy);
      x1_p_q[6]   <= x1_ctx_d.nb * x1_ctx_d.dy;
      x1_p_q[7]   <= 48'(x1_ctx_d.vtb * x1_ctx_d.dx);

      x2_ctx_q    <= x1_ctx_q;
      x2_num_q[0] <= 49'(x1_p_q[0]) - 49'(x1_p_q[1]);
      x2_num_q[1] <= 49'(x1_p_q[2]) + 49'(x1_p_q[3]);
      x2_num_q[2] <= 49'(x1_p_q[4]) - 49'(x1_p_q[5]);
      x2_num_q[3] <= 49'(x1_p_q[6]) + 49'(x1_p_q[7]);
    end
  end

  for (genvar g = 0; g < NDC; g++) begin : g_div_c
    cpc_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (DIV_NUM_W'(x2_num_q[g])),
      .den_i (DIV_DEN_W'(x2_ctx_q.ctr_dist)),
      .quo_o (qc[g])
    );
  end

  // --------------------------------------------------------------- output
  assign dc_ctx = dc_ctx_q[DIV_LAT-1];
  assign npax   = 25'(dc_ctx.item.a_pos_x) - 25'(dc_ctx.sx);
  assign npay   = 25'(dc_ctx.item.a_pos_y) - 25'(dc_ctx.sy);
  assign npbx   = 25'(dc_ctx.item.b_pos_x) + 25'(dc_ctx.sx);
  assign npby   = 25'(dc_ctx.item.b_pos_y) + 25'(dc_ctx.sy);

  always_comb begin
    out_d.new_a_pos_x = dc_ctx.item.a_pos_x;
    out_d.new_a_pos_y = dc_ctx.item.a_pos_y;
    out_d.new_a_vel_x = dc_ctx.item.a_vel_x;
    out_d.new_a_vel_y = dc_ctx.item.a_vel_y;
    out_d.new_b_pos_x = dc_ctx.item.b_pos_x;
    out_d.new_b_pos_y = dc_ctx.item.b_pos_y;
    out_d.new_b_vel_x = dc_ctx.item.b_vel_x;
    out_d.new_b_vel_y = dc_ctx.item.b_vel_y;
    out_d.status      = STAT_NONE;
    if (dc_ctx.degen) begin
      out_d.status = STAT_DEGEN;
    end else if (dc_ctx.hit) begin
      out_d.status      = STAT_HIT;
      out_d.new_a_pos_x = sat_val(SAT_IN_W'(npax));
      out_d.new_a_pos_y = sat_val(SAT_IN_W'(npay));
      out_d.new_b_pos_x = sat_val(SAT_IN_W'(npbx));
      out_d.new_b_pos_y = sat_val(SAT_IN_W'(npby));
      out_d.new_a_vel_x = sat_val(qc[0]);
      out_d.new_a_vel_y = sat_val(qc[1]);
      out_d.new_b_vel_x = sat_val(qc[2]);
      out_d.new_b_vel_y = sat_val(qc[3]);
    end
  end

  // hold the result beat until it is taken
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- design/cpc_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on cpc_pkg for widths.
module cpc_isqrt
  import cpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [SQ_IN_W-1:0]  rad_i,
  output logic [SQ_OUT_W-1:0] root_o
);

  localparam int unsigned RES_W = SQ_IN_W + 1;

  logic [RES_W-1:0] x_q   [SQ_OUT_W];
  logic [RES_W-1:0] r_q   [SQ_OUT_W];
  logic [RES_W-1:0] x_s   [SQ_OUT_W];
  logic [RES_W-1:0] r_s   [SQ_OUT_W];
  logic [RES_W-1:0] x_d   [SQ_OUT_W];
  logic [RES_W-1:0] r_d   [SQ_OUT_W];

  always_comb begin
    logic [RES_W-1:0] bitv;
    logic [RES_W-1:0] trial;
    x_s[0] = {1'b0, rad_i};
    r_s[0] = '0;
    for (int k = 1; k < SQ_OUT_W; k++) begin
      x_s[k] = x_q[k-1];
      r_s[k] = r_q[k-1];
    end
    for (int k = 0; k < SQ_OUT_W; k++) begin
      bitv  = RES_W'(1) << (2 * (SQ_OUT_W - 1 - k));
      trial = r_s[k] + bitv;
      if (x_s[k] >= trial) begin
        x_d[k] = x_s[k] - trial;
        r_d[k] = (r_s[k] >> 1) + bitv;
      end else begin
        x_d[k] = x_s[k];
        r_d[k] = r_s[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SQ_OUT_W; k++) begin
        x_q[k] <= x_d[k];
        r_q[k] <= r_d[k];
      end
    end
  end

  assign root_o = r_q[SQ_OUT_W-1][SQ_OUT_W-1:0];

endmodule

// ----- design/cpc_div.sv -----
// Pipelined signed divider, rounding half away from zero, positive divisor.
// Depends on cpc_pkg for widths.
module cpc_div
  import cpc_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0]        den_i,
  output logic signed [DIV_Q_W:0]     quo_o
);

  logic [DIV_REM_W-1:0] rem_q [DIV_Q_W+1];
  logic [DIV_DEN_W-1:0] den_q [DIV_Q_W+1];
  logic [DIV_Q_W-1:0]   quo_q [DIV_Q_W+1];
  logic                 neg_q [DIV_Q_W+1];
  logic [DIV_REM_W-1:0] rem_d [DIV_Q_W+1];
  logic [DIV_Q_W-1:0]   quo_d [DIV_Q_W+1];
  logic signed [DIV_Q_W:0] quo_s;

  always_comb begin
    logic [DIV_NUM_W-1:0] mag;
    logic [DIV_REM_W-1:0] trial;
    mag      = num_i[DIV_NUM_W-1] ? (~num_i + 1'b1) : num_i;
    // add half the divisor up front so truncation rounds
    rem_d[0] = {1'b0, mag} + DIV_REM_W'(den_i >> 1);
    quo_d[0] = '0;
    for (int k = 0; k < DIV_Q_W; k++) begin
      trial = DIV_REM_W'(den_q[k]) << (DIV_Q_W - 1 - k);
      if (rem_q[k] >= trial) begin
        rem_d[k+1] = rem_q[k] - trial;
        quo_d[k+1] = {quo_q[k][DIV_Q_W-2:0], 1'b1};
      end else begin
        rem_d[k+1] = rem_q[k];
        quo_d[k+1] = {quo_q[k][DIV_Q_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= rem_d[0];
      quo_q[0] <= quo_d[0];
      den_q[0] <= den_i;
      neg_q[0] <= num_i[DIV_NUM_W-1];
      for (int k = 1; k <= DIV_Q_W; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        den_q[k] <= den_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  assign quo_s = {1'b0, quo_q[DIV_Q_W]};
  assign quo_o = neg_q[DIV_Q_W] ? -quo_s : quo_s;

endmodule
